FILE: rtl/core/ralsu_pkg.sv
// Package for the rectangular area light sampler.
// Holds widths, stage counts, register indexes and the payload types
// used by the sampler core; its checker imports the pdf bounds.
package ralsu_pkg;

    localparam int CW = 20;
    localparam int REG_W = 3 * CW;
    localparam int SQ_STEPS = 21;
    localparam int CQ_BITS = 27;
    localparam int PQ_BITS = 49;
    localparam int PDF_W = 48;
    localparam logic signed [PDF_W-1:0] PDF_MAX = {1'b0, {(PDF_W-1){1'b1}}};
    localparam logic signed [PDF_W-1:0] PDF_MIN = {1'b1, {(PDF_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CFG_CENTER = 3'd0,
        CFG_EDGE_U = 3'd1,
        CFG_EDGE_V = 3'd2,
        CFG_FACING = 3'd3,
        CFG_AREA   = 3'd4,
        CFG_DOUBLE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0]   light;
        logic [41:0]        d2;
        logic signed [42:0] dot;
    } geo_t;

    typedef struct packed {
        logic [REG_W-1:0] light;
        logic             neg;
        logic             zero;
        logic             ovf;
    } pdf_t;

    function automatic logic signed [CW-1:0] comp_of(logic [REG_W-1:0] r, int idx);
        return $signed(r[idx*CW +: CW]);
    endfunction

endpackage

FILE: rtl/core/rect_area_light_sampler_unit.sv
// Top level of the rectangular area light sampler.
// Depends on ralsu_pkg for widths, register indexes and payload types.
//
// The block takes one item per cycle on the s_ channel: two 16-bit uniform
// fractions and a Q7.12 shading point. It places a sample on the rectangle
// set by the configuration registers and returns that point together with
// the solid-angle pdf and a saturation flag on the m_ channel.
// The user must write configuration through cfg_we, cfg_index and
// cfg_wdata only while no item is in flight; the block does not enforce it.
// The pipeline depth comes mostly from the bit-per-stage square root
// (21 stages), the cosine divider (27 stages) and the pdf divider
// (49 stages).
// Throughput is one item per cycle whenever the receiver takes results.
// When the receiver stalls with a result shown, the whole pipeline holds
// and s_tready falls until that result is taken; nothing is lost.
// Reset clears every valid bit and all configuration registers to zero.
module rect_area_light_sampler_unit
    import ralsu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // u_sample, v_sample, shade_x, shade_y, shade_z
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // light_x, light_y, light_z, pdf_value
    output logic [111:0] m_tdata,
    // pdf_saturated
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [59:0]  cfg_wdata
);

    logic [REG_W-1:0] center_reg, eu_reg, ev_reg, face_reg;
    logic [31:0]      area_reg;
    logic             dbl_reg;
    logic             en;

    logic                     a_v_reg;
    logic signed [37:0]       a_su_reg [3];
    logic signed [37:0]       a_tv_reg [3];
    logic signed [CW-1:0]     a_sh_reg [3];
    logic signed [37:0]       a_su_next [3];
    logic signed [37:0]       a_tv_next [3];
    logic signed [17:0]       s_val, t_val;

    logic                     b_v_reg;
    logic signed [CW-1:0]     b_p_reg [3];
    logic signed [CW-1:0]     b_sh_reg [3];
    logic signed [CW-1:0]     b_p_next [3];

    logic                     c_v_reg;
    logic signed [CW:0]       c_d_reg [3];
    logic [REG_W-1:0]         c_light_reg;

    logic                     d_v_reg;
    logic [39:0]              d_dd_reg [3];
    logic signed [40:0]       d_dn_reg [3];
    logic [39:0]              d_dd_next [3];
    logic signed [40:0]       d_dn_next [3];
    logic [REG_W-1:0]         d_light_reg;

    logic                     sq_v_reg [SQ_STEPS+1];
    logic [41:0]              sq_x_reg [SQ_STEPS+1];
    logic [42:0]              sq_r_reg [SQ_STEPS+1];
    geo_t                     sq_g_reg [SQ_STEPS+1];
    logic [41:0]              sq_x_next [SQ_STEPS+1];
    logic [42:0]              sq_r_next [SQ_STEPS+1];
    geo_t                     sq_g_next;

    logic                     cq_v_reg [CQ_BITS+1];
    logic [CQ_BITS-1:0]       cq_n_reg [CQ_BITS+1];
    logic [21:0]              cq_rem_reg [CQ_BITS+1];
    logic [21:0]              cq_div_reg [CQ_BITS+1];
    logic [CQ_BITS-1:0]       cq_q_reg [CQ_BITS+1];
    logic                     cq_z_reg [CQ_BITS+1];
    geo_t                     cq_g_reg [CQ_BITS+1];
    logic [CQ_BITS-1:0]       cq_n_next [CQ_BITS+1];
    logic [21:0]              cq_rem_next [CQ_BITS+1];
    logic [CQ_BITS-1:0]       cq_q_next [CQ_BITS+1];

    logic                     p0_v_reg;
    logic [58:0]              p0_den_reg;
    logic                     p0_neg_reg;
    geo_t                     p0_g_reg;
    logic [CQ_BITS-1:0]       cosm;

    logic                     pq_v_reg [PQ_BITS+1];
    logic [PQ_BITS-1:0]       pq_n_reg [PQ_BITS+1];
    logic [58:0]              pq_rem_reg [PQ_BITS+1];
    logic [58:0]              pq_den_reg [PQ_BITS+1];
    logic [PQ_BITS-1:0]       pq_q_reg [PQ_BITS+1];
    pdf_t                     pq_f_reg [PQ_BITS+1];
    logic [PQ_BITS-1:0]       pq_n_next [PQ_BITS+1];
    logic [58:0]              pq_rem_next [PQ_BITS+1];
    logic [PQ_BITS-1:0]       pq_q_next [PQ_BITS+1];
    logic [62:0]              pnum;
    pdf_t                     pq_f_next;

    logic                     m_valid_reg;
    logic [111:0]             m_data_reg;
    logic                     m_flag_reg;
    logic [111:0]             m_data_next;
    logic                     m_flag_next;

    assign en = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            eu_reg <= '0;
            ev_reg <= '0;
            face_reg <= '0;
            area_reg <= '0;
            dbl_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER: center_reg <= cfg_wdata;
                CFG_EDGE_U: eu_reg <= cfg_wdata;
                CFG_EDGE_V: ev_reg <= cfg_wdata;
                CFG_FACING: face_reg <= cfg_wdata;
                CFG_AREA:   area_reg <= cfg_wdata[31:0];
                CFG_DOUBLE: dbl_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [39:0] acc;
        logic signed [23:0] p24;
        logic signed [41:0] sqf;
        logic [42:0]        bb;
        logic [22:0]        ct;
        logic [59:0]        pt;
        logic [42:0]        dabs;
        logic [47:0]        num;

        s_val = $signed({1'b0, s_tdata[15:0], 1'b0}) - 18'sd65536;
        t_val = $signed({1'b0, s_tdata[31:16], 1'b0}) - 18'sd65536;
        for (int k = 0; k < 3; k++) begin
            a_su_next[k] = s_val * comp_of(eu_reg, k);
            a_tv_next[k] = t_val * comp_of(ev_reg, k);

            acc = (40'(comp_of(center_reg, k)) <<< 16) + 40'(a_su_reg[k])
                + 40'(a_tv_reg[k]) + 40'sd32768;
            p24 = 24'(acc >>> 16);
            if (p24 > 24'sd524287) begin
                b_p_next[k] = {1'b0, {(CW-1){1'b1}}};
            end else if (p24 < -24'sd524288) begin
                b_p_next[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                b_p_next[k] = CW'(p24);
            end

            sqf = c_d_reg[k] * c_d_reg[k];
            d_dd_next[k] = sqf[39:0];
            d_dn_next[k] = c_d_reg[k] * comp_of(face_reg, k);
        end

        sq_x_next[0] = 42'(d_dd_reg[0]) + 42'(d_dd_reg[1]) + 42'(d_dd_reg[2]);
        sq_r_next[0] = '0;
        sq_g_next.light = d_light_reg;
        sq_g_next.d2 = sq_x_next[0];
        sq_g_next.dot = 43'(d_dn_reg[0]) + 43'(d_dn_reg[1]) + 43'(d_dn_reg[2]);
        for (int k = 0; k < SQ_STEPS; k++) begin
            bb = 43'(1) << (2 * (SQ_STEPS - 1 - k));
            if ({1'b0, sq_x_reg[k]} >= sq_r_reg[k] + bb) begin
                sq_x_next[k+1] = 42'({1'b0, sq_x_reg[k]} - sq_r_reg[k] - bb);
                sq_r_next[k+1] = (sq_r_reg[k] >> 1) + bb;
            end else begin
                sq_x_next[k+1] = sq_x_reg[k];
                sq_r_next[k+1] = sq_r_reg[k] >> 1;
            end
        end

        dabs = sq_g_reg[SQ_STEPS].dot[42] ? 43'(-sq_g_reg[SQ_STEPS].dot)
                                          : 43'(sq_g_reg[SQ_STEPS].dot);
        num = 48'({dabs, 5'b0}) + 48'(sq_r_reg[SQ_STEPS][20:0]);
        cq_n_next[0] = num[CQ_BITS-1:0];
        cq_rem_next[0] = 22'(num[47:CQ_BITS]);
        cq_q_next[0] = '0;
        for (int j = 0; j < CQ_BITS; j++) begin
            ct = {cq_rem_reg[j], cq_n_reg[j][CQ_BITS-1]};
            cq_n_next[j+1] = cq_n_reg[j] << 1;
            if (ct >= {1'b0, cq_div_reg[j]}) begin
                cq_rem_next[j+1] = 22'(ct - {1'b0, cq_div_reg[j]});
                cq_q_next[j+1] = {cq_q_reg[j][CQ_BITS-2:0], 1'b1};
            end else begin
                cq_rem_next[j+1] = ct[21:0];
                cq_q_next[j+1] = {cq_q_reg[j][CQ_BITS-2:0], 1'b0};
            end
        end
        cosm = cq_z_reg[CQ_BITS] ? '0 : cq_q_reg[CQ_BITS];

        pnum = {p0_g_reg.d2[41:0], 20'b0} + 63'(p0_den_reg >> 1);
        pq_f_next.light = p0_g_reg.light;
        pq_f_next.neg = p0_neg_reg;
        pq_f_next.zero = (p0_den_reg == '0);
        pq_f_next.ovf = 59'(pnum[62:PQ_BITS]) >= p0_den_reg;
        pq_n_next[0] = pnum[PQ_BITS-1:0];
        pq_rem_next[0] = 59'(pnum[62:PQ_BITS]);
        pq_q_next[0] = '0;
        for (int j = 0; j < PQ_BITS; j++) begin
            pt = {pq_rem_reg[j], pq_n_reg[j][PQ_BITS-1]};
            pq_n_next[j+1] = pq_n_reg[j] << 1;
            if (pt >= {1'b0, pq_den_reg[j]}) begin
                pq_rem_next[j+1] = 59'(pt - {1'b0, pq_den_reg[j]});
                pq_q_next[j+1] = {pq_q_reg[j][PQ_BITS-2:0], 1'b1};
            end else begin
                pq_rem_next[j+1] = pt[58:0];
                pq_q_next[j+1] = {pq_q_reg[j][PQ_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [PQ_BITS-1:0]     q;
        logic [PDF_W-1:0]       pdf;
        logic                   flag;

        q = pq_q_reg[PQ_BITS];
        flag = 1'b0;
        if (pq_f_reg[PQ_BITS].zero) begin
            pdf = PDF_MAX;
            flag = 1'b1;
        end else if (pq_f_reg[PQ_BITS].neg) begin
            if (pq_f_reg[PQ_BITS].ovf || q > (PQ_BITS'(1) << (PDF_W - 1))) begin
                pdf = PDF_MIN;
                flag = 1'b1;
            end else begin
                pdf = PDF_W'(-q);
            end
        end else begin
            if (pq_f_reg[PQ_BITS].ovf || q > PQ_BITS'(PDF_MAX)) begin
                pdf = PDF_MAX;
                flag = 1'b1;
            end else begin
                pdf = q[PDF_W-1:0];
            end
        end
        m_data_next = {4'b0, pdf, pq_f_reg[PQ_BITS].light};
        m_flag_next = flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            p0_v_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= CQ_BITS; k++) cq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= PQ_BITS; k++) pq_v_reg[k] <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            sq_v_reg[0] <= d_v_reg;
            for (int k = 0; k < SQ_STEPS; k++) sq_v_reg[k+1] <= sq_v_reg[k];
            cq_v_reg[0] <= sq_v_reg[SQ_STEPS];
            for (int k = 0; k < CQ_BITS; k++) cq_v_reg[k+1] <= cq_v_reg[k];
            p0_v_reg <= cq_v_reg[CQ_BITS];
            pq_v_reg[0] <= p0_v_reg;
            for (int k = 0; k < PQ_BITS; k++) pq_v_reg[k+1] <= pq_v_reg[k];
            m_valid_reg <= pq_v_reg[PQ_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_su_reg[k] <= a_su_next[k];
                a_tv_reg[k] <= a_tv_next[k];
                a_sh_reg[k] <= $signed(s_tdata[32 + k*CW +: CW]);
                b_p_reg[k] <= b_p_next[k];
                b_sh_reg[k] <= a_sh_reg[k];
                c_d_reg[k] <= (CW+1)'(b_sh_reg[k]) - (CW+1)'(b_p_reg[k]);
                d_dd_reg[k] <= d_dd_next[k];
                d_dn_reg[k] <= d_dn_next[k];
            end
            c_light_reg <= {b_p_reg[2], b_p_reg[1], b_p_reg[0]};
            d_light_reg <= c_light_reg;

            sq_x_reg[0] <= sq_x_next[0];
            sq_r_reg[0] <= sq_r_next[0];
            sq_g_reg[0] <= sq_g_next;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_x_reg[k+1] <= sq_x_next[k+1];
                sq_r_reg[k+1] <= sq_r_next[k+1];
                sq_g_reg[k+1] <= sq_g_reg[k];
            end

            cq_n_reg[0] <= cq_n_next[0];
            cq_rem_reg[0] <= cq_rem_next[0];
            cq_q_reg[0] <= cq_q_next[0];
            cq_div_reg[0] <= {sq_r_reg[SQ_STEPS][20:0], 1'b0};
            cq_z_reg[0] <= (sq_r_reg[SQ_STEPS] == '0);
            cq_g_reg[0] <= sq_g_reg[SQ_STEPS];
            for (int j = 0; j < CQ_BITS; j++) begin
                cq_n_reg[j+1] <= cq_n_next[j+1];
                cq_rem_reg[j+1] <= cq_rem_next[j+1];
                cq_q_reg[j+1] <= cq_q_next[j+1];
                cq_div_reg[j+1] <= cq_div_reg[j];
                cq_z_reg[j+1] <= cq_z_reg[j];
                cq_g_reg[j+1] <= cq_g_reg[j];
            end

            p0_den_reg <= area_reg * cosm;
            p0_neg_reg <= cq_g_reg[CQ_BITS].dot[42] && !dbl_reg && (cosm != '0);
            p0_g_reg <= cq_g_reg[CQ_BITS];

            pq_n_reg[0] <= pq_n_next[0];
            pq_rem_reg[0] <= pq_rem_next[0];
            pq_q_reg[0] <= pq_q_next[0];
            pq_den_reg[0] <= p0_den_reg;
            pq_f_reg[0] <= pq_f_next;
            for (int j = 0; j < PQ_BITS; j++) begin
                pq_n_reg[j+1] <= pq_n_next[j+1];
                pq_rem_reg[j+1] <= pq_rem_next[j+1];
                pq_q_reg[j+1] <= pq_q_next[j+1];
                pq_den_reg[j+1] <= pq_den_reg[j];
                pq_f_reg[j+1] <= pq_f_reg[j];
            end

            m_data_reg <= m_data_next;
            m_flag_reg <= m_flag_next;
        end
    end

endmodule

FILE: rtl/core/ralsu_checker.sv
// Port-level checker for the rectangular area light sampler.
// Depends on ralsu_pkg and is bound to rect_area_light_sampler_unit.
module ralsu_checker
    import ralsu_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without an output stall");

    a_flag_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[107:60] == PDF_MAX || m_tdata[107:60] == PDF_MIN)
        else $error("flagged pdf is not a saturated value");

endmodule

bind rect_area_light_sampler_unit ralsu_checker u_ralsu_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);
